// ===== rtl/sltok_pkg.sv =====
// Shared types and constants for the shell line tokenizer.
// Used by sltok_lexer, sltok_outq and shell_line_tokenizer; depends on nothing.
package sltok_pkg;

  localparam int LINE_MAX_DEF = 4096;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_PIPE    = 3'd1,
    KIND_IN      = 3'd2,
    KIND_OUT     = 3'd3,
    KIND_APPEND  = 3'd4,
    KIND_HEREDOC = 3'd5
  } token_kind_t;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_GT   = 2'd1,
    HELD_LT   = 2'd2
  } held_op_t;

  typedef struct packed {
    token_kind_t kind;
    logic [11:0] start;
    logic [12:0] length;
    logic [11:0] number;
    logic [11:0] pipes;
    logic        run_last;
  } token_t;

endpackage

// ===== rtl/sltok_lexer.sv =====
// Per-byte lexer state and token generation for the shell line tokenizer.
// Depends on sltok_pkg; produces up to two tokens for each stepped byte.
module sltok_lexer #(
  parameter int LINE_MAX = sltok_pkg::LINE_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        line_byte,
  input  logic              line_last,
  output sltok_pkg::token_t res0,
  output sltok_pkg::token_t res1,
  output logic [1:0]        res_cnt
);
  import sltok_pkg::*;

  localparam int POS_W = $clog2(LINE_MAX + 1);
  localparam int ORG_W = $clog2(LINE_MAX);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_MAX);
  localparam logic [ORG_W-1:0] ORG_MAX = ORG_W'(LINE_MAX - 1);

  typedef struct packed {
    logic              v;
    token_kind_t       kind;
    logic [ORG_W-1:0]  start;
    logic [POS_W-1:0]  stop;
  } emit_t;

  logic             word_open_r, word_open_nxt;
  logic             quote_open_r, quote_open_nxt;
  logic             quote_dbl_r, quote_dbl_nxt;
  logic             seg_begin_r, seg_begin_nxt;
  logic [ORG_W-1:0] origin_r, origin_nxt;
  held_op_t         held_r, held_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [11:0]      tok_cnt_r, tok_cnt_nxt;
  logic [11:0]      pipe_cnt_r, pipe_cnt_nxt;

  emit_t            e_op, e_pipe, e_flush;
  emit_t            sel0, sel1;
  logic             do_idle;
  logic             sel0_early;
  logic [11:0]      pipe_after;
  logic [POS_W:0]   pos_inc;
  logic [7:0]       held_ch;
  logic [7:0]       quote_ch;
  logic             is_quote;

  function automatic logic [ORG_W-1:0] clamp_start(input logic [POS_W-1:0] p);
    return (p < POS_W'(LINE_MAX - 1)) ? ORG_W'(p) : ORG_MAX;
  endfunction

  function automatic logic [POS_W-1:0] clamp_end(input logic [POS_W:0] e);
    return (e < (POS_W+1)'(LINE_MAX)) ? POS_W'(e) : POS_MAX;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [11:0] sat_inc(input logic [11:0] x);
    return (x == COUNT_MAX) ? x : x + 12'd1;
  endfunction

  function automatic logic [12:0] tok_len(input emit_t e);
    return (e.stop > POS_W'(e.start)) ? 13'(e.stop - POS_W'(e.start)) : 13'd1;
  endfunction

  assign pos_inc  = {1'b0, pos_r} + (POS_W+1)'(1);
  assign held_ch  = (held_r == HELD_GT) ? CH_GT : CH_LT;
  assign quote_ch = quote_dbl_r ? CH_DQUOT : CH_SQUOT;
  assign is_quote = (line_byte == CH_SQUOT) || (line_byte == CH_DQUOT);

  always_comb begin
    word_open_nxt  = word_open_r;
    quote_open_nxt = quote_open_r;
    quote_dbl_nxt  = quote_dbl_r;
    seg_begin_nxt  = seg_begin_r;
    origin_nxt     = origin_r;
    held_nxt       = held_r;
    pos_nxt        = pos_r;
    e_op           = '0;
    e_pipe         = '0;
    e_flush        = '0;
    do_idle        = 1'b0;

    // A held bracket and an open word never coexist.
    if (held_r != HELD_NONE) begin
      held_nxt = HELD_NONE;
      e_op.v     = 1'b1;
      e_op.start = origin_r;
      if (line_byte == held_ch) begin
        e_op.kind = (held_r == HELD_GT) ? KIND_APPEND : KIND_HEREDOC;
        e_op.stop = clamp_end(pos_inc);
      end else begin
        e_op.kind = (held_r == HELD_GT) ? KIND_OUT : KIND_IN;
        e_op.stop = clamp_end((POS_W+1)'(origin_r) + (POS_W+1)'(1));
        do_idle   = 1'b1;
      end
    end else if (word_open_r) begin
      if (quote_open_r) begin
        if (line_byte == quote_ch) begin
          quote_open_nxt = 1'b0;
          seg_begin_nxt  = 1'b1;
        end
      end else if (is_blank(line_byte) || line_byte == CH_PIPE ||
                   line_byte == CH_LT || line_byte == CH_GT) begin
        e_op.v         = 1'b1;
        e_op.kind      = KIND_WORD;
        e_op.start     = origin_r;
        e_op.stop      = pos_r;
        word_open_nxt  = 1'b0;
        seg_begin_nxt  = 1'b0;
        do_idle        = 1'b1;
      end else if (seg_begin_r && is_quote) begin
        quote_open_nxt = 1'b1;
        quote_dbl_nxt  = (line_byte == CH_DQUOT);
        seg_begin_nxt  = 1'b0;
      end else begin
        seg_begin_nxt  = 1'b0;
      end
    end else begin
      do_idle = 1'b1;
    end

    // Byte seen with no word open and no bracket held, or one that just ended them.
    if (do_idle && !is_blank(line_byte)) begin
      if (line_byte == CH_PIPE) begin
        e_pipe.v     = 1'b1;
        e_pipe.kind  = KIND_PIPE;
        e_pipe.start = clamp_start(pos_r);
        e_pipe.stop  = clamp_end(pos_inc);
      end else if (line_byte == CH_GT || line_byte == CH_LT) begin
        held_nxt   = (line_byte == CH_GT) ? HELD_GT : HELD_LT;
        origin_nxt = clamp_start(pos_r);
      end else begin
        word_open_nxt  = 1'b1;
        origin_nxt     = clamp_start(pos_r);
        quote_open_nxt = is_quote;
        quote_dbl_nxt  = is_quote ? (line_byte == CH_DQUOT) : quote_dbl_r;
        seg_begin_nxt  = 1'b0;
      end
    end

    if (line_last) begin
      if (word_open_nxt) begin
        e_flush.v     = 1'b1;
        e_flush.kind  = KIND_WORD;
        e_flush.start = origin_nxt;
        e_flush.stop  = clamp_end(pos_inc);
      end else if (held_nxt != HELD_NONE) begin
        e_flush.v     = 1'b1;
        e_flush.kind  = (held_nxt == HELD_GT) ? KIND_OUT : KIND_IN;
        e_flush.start = origin_nxt;
        e_flush.stop  = clamp_end((POS_W+1)'(origin_nxt) + (POS_W+1)'(1));
      end
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Pack the up to three candidate tokens into two slots, in order.
  always_comb begin
    res_cnt    = 2'(e_op.v) + 2'(e_pipe.v) + 2'(e_flush.v);
    sel0_early = e_op.v;
    if (e_op.v) begin
      sel0 = e_op;
      sel1 = e_pipe.v ? e_pipe : e_flush;
    end else if (e_pipe.v) begin
      sel0 = e_pipe;
      sel1 = e_flush;
    end else begin
      sel0 = e_flush;
      sel1 = '0;
    end
    pipe_after = e_pipe.v ? sat_inc(pipe_cnt_r) : pipe_cnt_r;

    res0.kind     = sel0.kind;
    res0.start    = 12'(sel0.start);
    res0.length   = tok_len(sel0);
    res0.number   = tok_cnt_r;
    res0.pipes    = sel0_early ? pipe_cnt_r : pipe_after;
    res0.run_last = (res_cnt == 2'd1);

    res1.kind     = sel1.kind;
    res1.start    = 12'(sel1.start);
    res1.length   = tok_len(sel1);
    res1.number   = sat_inc(tok_cnt_r);
    res1.pipes    = pipe_after;
    res1.run_last = 1'b1;

    tok_cnt_nxt  = (res_cnt == 2'd2) ? sat_inc(sat_inc(tok_cnt_r)) :
                   (res_cnt == 2'd1) ? sat_inc(tok_cnt_r) : tok_cnt_r;
    pipe_cnt_nxt = pipe_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_open_r  <= 1'b0;
      quote_open_r <= 1'b0;
      quote_dbl_r  <= 1'b0;
      seg_begin_r  <= 1'b0;
      origin_r     <= '0;
      held_r       <= HELD_NONE;
      pos_r        <= '0;
      tok_cnt_r    <= '0;
      pipe_cnt_r   <= '0;
    end else if (step_en) begin
      if (line_last) begin
        word_open_r  <= 1'b0;
        quote_open_r <= 1'b0;
        quote_dbl_r  <= 1'b0;
        seg_begin_r  <= 1'b0;
        origin_r     <= '0;
        held_r       <= HELD_NONE;
        pos_r        <= '0;
        tok_cnt_r    <= '0;
        pipe_cnt_r   <= '0;
      end else begin
        word_open_r  <= word_open_nxt;
        quote_open_r <= quote_open_nxt;
        quote_dbl_r  <= quote_dbl_nxt;
        seg_begin_r  <= seg_begin_nxt;
        origin_r     <= origin_nxt;
        held_r       <= held_nxt;
        pos_r        <= pos_nxt;
        tok_cnt_r    <= tok_cnt_nxt;
        pipe_cnt_r   <= pipe_cnt_nxt;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && line_last |=> pos_r == '0 && !word_open_r && held_r == HELD_NONE)
    else $error("line state not cleared after final byte");

  a_word_held_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(word_open_r && held_r != HELD_NONE))
    else $error("open word and held bracket at the same time");

  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> res_cnt <= 2'd2 && (res_cnt != 2'd2 || !res0.run_last))
    else $error("bad result count from one byte");

endmodule

// ===== rtl/sltok_outq.sv =====
// Small result queue for the shell line tokenizer: up to two pushes, one pop.
// Depends on sltok_pkg for the token type and queue depth.
module sltok_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  sltok_pkg::token_t push0,
  input  sltok_pkg::token_t push1,
  input  logic              pop,
  output sltok_pkg::token_t head,
  output logic              not_empty,
  output logic              room2
);
  import sltok_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t           mem_r [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + IDX_W'(1);
  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign count_nxt = count_r + CNT_W'(push_cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + IDX_W'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + IDX_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> count_r <= CNT_W'(QUEUE_DEPTH - 2))
    else $error("push into queue without room for two requests");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH) && (!pop || count_r != '0))
    else $error("queue count out of range or pop while empty");

endmodule

// ===== rtl/shell_line_tokenizer.sv =====
// Shell command line tokenizer: one byte of the line per input request,
// tokens as start, length, kind, index and pipe count per result request.
// Path: a byte taken is held in the staging register, then stepped through
// the lexer into the result queue, from which its first token is offered.
// Throughput: one byte per cycle when not held off. A byte can yield two
// tokens; the queue then drains one per cycle, so a run of such bytes
// paces the input at the output rate. The input is held off while a byte is
// staged and the queue has fewer than two free entries.
// Channels: in_valid/in_ready carry in_line_byte and in_line_last;
// out_valid/out_ready carry the token fields. out_run_last marks the last
// token caused by one byte. A stalled receiver fills the four-entry queue;
// with under two entries free, in_ready drops; nothing is lost or duplicated.
// Reset (rst_n low, synchronous) empties the queue and clears all line
// state. A byte with in_line_last set flushes any pending word or bracket
// and returns the line state to its reset values.
// Depends on sltok_pkg, sltok_lexer and sltok_outq.
module shell_line_tokenizer #(
  parameter int LINE_MAX = sltok_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_line_byte,
  input  logic        in_line_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [11:0] out_token_start,
  output logic [12:0] out_token_length,
  output logic [11:0] out_token_number,
  output logic [11:0] out_pipes_seen,
  output logic        out_run_last
);
  import sltok_pkg::*;

  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       step_en;
  logic       room2;
  token_t     res0, res1, head;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;

  // The staged byte is processed only when the queue can take both tokens.
  assign step_en  = stg_v_r && room2;
  assign in_ready = !stg_v_r || step_en;
  assign push_cnt = step_en ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_v_r <= 1'b1;
    end else if (step_en) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_line_byte;
      stg_last_r <= in_line_last;
    end
  end

  sltok_lexer #(
    .LINE_MAX(LINE_MAX)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .line_byte(stg_byte_r),
    .line_last(stg_last_r),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  sltok_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .pop      (out_valid && out_ready),
    .head     (head),
    .not_empty(out_valid),
    .room2    (room2)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_token_number = head.number;
  assign out_pipes_seen   = head.pipes;
  assign out_run_last     = head.run_last;

endmodule
